@@ hw/rtl/iupx_pkg.sv @@
// Shared types and constants of the ident reply username extractor.
`default_nettype none
package iupx_pkg;

    localparam int MAX_REPLY  = 128;
    localparam int BCNT_W     = $clog2(MAX_REPLY + 1);
    localparam int LIMIT_W    = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_U     = 8'h55;

    localparam logic KIND_USER   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_THIRD  = 3'd2,
        PH_COPY   = 3'd3,
        PH_STOP   = 3'd4,
        PH_REJECT = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        NS_WS   = 2'd0,
        NS_SIGN = 2'd1,
        NS_DIG  = 2'd2,
        NS_DONE = 2'd3
    } t_numst;

    typedef struct packed {
        t_numst stage;
        logic   nz;
    } t_num_res;

    typedef struct packed {
        logic       kind;
        logic [7:0] user_byte;
        logic       success;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage
`default_nettype wire

@@ hw/rtl/iupx_parser.sv @@
// Reply parsing state and per-beat result generation.
`default_nettype none
module iupx_parser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_advance,
    input  wire logic [7:0]                   i_byte,
    input  wire logic                         i_last,
    input  wire logic [iupx_pkg::LIMIT_W-1:0] i_user_limit,
    output iupx_pkg::t_push                   o_push
);

    iupx_pkg::t_phase                  r_phase, n_phase;
    iupx_pkg::t_numst                  r_numst, n_numst;
    logic                              r_comma, n_comma;
    logic                              r_rnz, n_rnz;
    logic                              r_lnz, n_lnz;
    logic [2:0]                        r_match, n_match;
    logic                              r_kwf, n_kwf;
    logic                              r_lskip, n_lskip;
    logic [iupx_pkg::LIMIT_W-1:0]      r_copied, n_copied;
    logic                              r_ended, n_ended;
    logic [iupx_pkg::BCNT_W-1:0]       r_bcount, n_bcount;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c inside {iupx_pkg::CH_SPACE, [iupx_pkg::CH_TAB:iupx_pkg::CH_CR]});
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        case (idx)
            3'd0:    kw_char = 8'h55;
            3'd1:    kw_char = 8'h53;
            3'd2:    kw_char = 8'h45;
            3'd3:    kw_char = 8'h52;
            3'd4:    kw_char = 8'h49;
            3'd5:    kw_char = 8'h44;
            default: kw_char = iupx_pkg::CH_NUL;
        endcase
    endfunction

    function automatic iupx_pkg::t_num_res num_step(input iupx_pkg::t_numst st,
                                                    input logic [7:0] c);
        iupx_pkg::t_num_res r;
        logic               dig;
        r.stage = st;
        r.nz    = 1'b0;
        dig     = (c inside {[iupx_pkg::CH_ZERO:iupx_pkg::CH_NINE]});
        case (st)
            iupx_pkg::NS_WS, iupx_pkg::NS_SIGN, iupx_pkg::NS_DIG: begin
                if (st == iupx_pkg::NS_WS && is_ws(c)) begin
                    r.stage = st;
                end else if (st == iupx_pkg::NS_WS &&
                             (c == iupx_pkg::CH_PLUS || c == iupx_pkg::CH_MINUS)) begin
                    r.stage = iupx_pkg::NS_SIGN;
                end else if (dig) begin
                    r.stage = iupx_pkg::NS_DIG;
                    r.nz    = (c != iupx_pkg::CH_ZERO);
                end else begin
                    r.stage = iupx_pkg::NS_DONE;
                end
            end
            default: r.stage = st;
        endcase
        num_step = r;
    endfunction

    iupx_pkg::t_num_res nres;
    logic               user_hit;
    logic               ok;
    iupx_pkg::t_result  user_res, stat_res;

    always_comb begin
        n_phase  = r_phase;
        n_numst  = r_numst;
        n_comma  = r_comma;
        n_rnz    = r_rnz;
        n_lnz    = r_lnz;
        n_match  = r_match;
        n_kwf    = r_kwf;
        n_lskip  = r_lskip;
        n_copied = r_copied;
        n_ended  = r_ended;
        n_bcount = r_bcount;
        user_hit = 1'b0;
        nres     = num_step(r_numst, i_byte);
        ok       = r_comma && r_rnz && r_lnz && r_kwf;

        if (i_advance && !r_ended && r_bcount < iupx_pkg::BCNT_W'(iupx_pkg::MAX_REPLY)) begin
            n_bcount = r_bcount + 1'b1;
            if (i_byte == iupx_pkg::CH_NUL) begin
                n_ended = 1'b1;
            end else begin
                case (r_phase)
                    iupx_pkg::PH_FIRST: begin
                        if (i_byte == iupx_pkg::CH_COLON) begin
                            n_phase = iupx_pkg::PH_SECOND;
                        end else if (i_byte == iupx_pkg::CH_COMMA && !r_comma) begin
                            n_comma = 1'b1;
                            n_numst = iupx_pkg::NS_WS;
                        end else begin
                            n_numst = nres.stage;
                            if (r_comma) begin
                                n_lnz = r_lnz | nres.nz;
                            end else begin
                                n_rnz = r_rnz | nres.nz;
                            end
                        end
                    end
                    iupx_pkg::PH_SECOND: begin
                        if (i_byte == iupx_pkg::CH_COLON) begin
                            n_phase = iupx_pkg::PH_THIRD;
                        end else if (!r_kwf) begin
                            if (i_byte == kw_char(r_match)) begin
                                if (r_match == 3'd5) begin
                                    n_kwf   = 1'b1;
                                    n_match = 3'd0;
                                end else begin
                                    n_match = r_match + 3'd1;
                                end
                            end else begin
                                n_match = (i_byte == iupx_pkg::CH_U) ? 3'd1 : 3'd0;
                            end
                        end
                    end
                    iupx_pkg::PH_THIRD: begin
                        if (i_byte == iupx_pkg::CH_COLON) begin
                            n_phase = ok ? iupx_pkg::PH_COPY : iupx_pkg::PH_REJECT;
                        end
                    end
                    iupx_pkg::PH_COPY: begin
                        if (!(r_lskip && (i_byte == iupx_pkg::CH_TILDE ||
                                          i_byte == iupx_pkg::CH_CARET))) begin
                            n_lskip = 1'b0;
                            if (r_copied >= i_user_limit || i_byte == iupx_pkg::CH_AT) begin
                                n_phase = iupx_pkg::PH_STOP;
                            end else if (!is_ws(i_byte) && i_byte != iupx_pkg::CH_COLON &&
                                         i_byte != iupx_pkg::CH_LBRK) begin
                                user_hit = 1'b1;
                                n_copied = r_copied + 1'b1;
                                if ({1'b0, r_copied} + 6'd1 >= {1'b0, i_user_limit}) begin
                                    n_phase = iupx_pkg::PH_STOP;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        user_res.kind      = iupx_pkg::KIND_USER;
        user_res.user_byte = i_byte;
        user_res.success   = 1'b0;
        stat_res.kind      = iupx_pkg::KIND_STATUS;
        stat_res.user_byte = 8'd0;
        stat_res.success   = (n_phase == iupx_pkg::PH_COPY || n_phase == iupx_pkg::PH_STOP);

        o_push.count  = 2'd0;
        o_push.first  = stat_res;
        o_push.second = stat_res;
        if (i_advance) begin
            if (user_hit) begin
                o_push.first = user_res;
                o_push.count = i_last ? 2'd2 : 2'd1;
            end else if (i_last) begin
                o_push.count = 2'd1;
            end
        end

        if (i_advance && i_last) begin
            n_phase  = iupx_pkg::PH_FIRST;
            n_numst  = iupx_pkg::NS_WS;
            n_comma  = 1'b0;
            n_rnz    = 1'b0;
            n_lnz    = 1'b0;
            n_match  = 3'd0;
            n_kwf    = 1'b0;
            n_lskip  = 1'b1;
            n_copied = '0;
            n_ended  = 1'b0;
            n_bcount = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= iupx_pkg::PH_FIRST;
            r_numst  <= iupx_pkg::NS_WS;
            r_comma  <= 1'b0;
            r_rnz    <= 1'b0;
            r_lnz    <= 1'b0;
            r_match  <= 3'd0;
            r_kwf    <= 1'b0;
            r_lskip  <= 1'b1;
            r_copied <= '0;
            r_ended  <= 1'b0;
            r_bcount <= '0;
        end else begin
            r_phase  <= n_phase;
            r_numst  <= n_numst;
            r_comma  <= n_comma;
            r_rnz    <= n_rnz;
            r_lnz    <= n_lnz;
            r_match  <= n_match;
            r_kwf    <= n_kwf;
            r_lskip  <= n_lskip;
            r_copied <= n_copied;
            r_ended  <= n_ended;
            r_bcount <= n_bcount;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/iupx_res_fifo.sv @@
// Result queue: takes up to two results a cycle, delivers one beat a cycle unless stalled.
`default_nettype none
module iupx_res_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire iupx_pkg::t_push   i_push,
    output logic                   o_room2,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output iupx_pkg::t_result      o_res
);

    iupx_pkg::t_result                 r_mem [iupx_pkg::FIFO_DEPTH];
    logic [iupx_pkg::FPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [iupx_pkg::FPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [iupx_pkg::FCNT_W-1:0]       r_count, n_count;
    logic                              pop;
    logic [iupx_pkg::FPTR_W-1:0]       wr_ptr2;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= iupx_pkg::FCNT_W'(iupx_pkg::FIFO_DEPTH - 2));
    assign pop     = o_valid && !i_stall;
    assign wr_ptr2 = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + iupx_pkg::FPTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + iupx_pkg::FPTR_W'(pop);
        n_count  = r_count + iupx_pkg::FCNT_W'(i_push.count) - iupx_pkg::FCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr2] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ident_reply_username_extractor_top.sv @@
// Top level of the ident reply username extractor.
//
// Input channel: one reply byte per beat (i_reply_byte, i_last marks the
// final byte of a reply). Output channel: one result per beat; o_kind 0 is
// a username character in o_user_byte, o_kind 1 is the status of the reply
// in o_success and always closes that reply's results.
// The limit register (i_cfg_wr_en, i_cfg_wr_data) sets the most username
// characters copied; write it only while no reply is in flight.
// A taken beat waits in the input register until the result queue has room
// for two results, then is parsed and its results queued. Throughput:
// one byte per cycle while the queue has that room; the reply's parse state
// is updated by a single logic step between the input register and queue.
// A final byte that also yields a username character produces two results
// and so needs two output beats; the four-entry result queue absorbs this
// and o_in_stall rises only when it cannot take two more results.
// Reset (synchronous, active low) empties the queue, clears the parse
// state and sets the limit to 10. A stalling receiver holds the offered
// result unchanged; input keeps flowing until the queue cannot take two more.
`default_nettype none
module ident_reply_username_extractor_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [7:0]                   i_reply_byte,
    input  wire logic                         i_last,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_kind,
    output logic [7:0]                        o_user_byte,
    output logic                              o_success,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [iupx_pkg::LIMIT_W-1:0] i_cfg_wr_data
);

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_last;
    logic [iupx_pkg::LIMIT_W-1:0] r_user_limit;
    logic                         room2;
    logic                         advance;
    iupx_pkg::t_push              push;
    iupx_pkg::t_result            res;

    assign advance    = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_user_limit <= iupx_pkg::LIMIT_RESET;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_user_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_reply_byte;
            r_in_last <= i_last;
        end
    end

    iupx_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_user_limit (r_user_limit),
        .o_push       (push)
    );

    iupx_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res)
    );

    assign o_kind      = res.kind;
    assign o_user_byte = res.user_byte;
    assign o_success   = res.success;

endmodule
`default_nettype wire
